[sv/assert_macros.svh]
// Assertion macros used by the checker file of this project.
// Depends on nothing; included by the file that holds assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/ddm_pkg.sv]
// Types and constants of the detection merge block.
// Depends on nothing; used by every module of the block.
package ddm_pkg;

    localparam logic [2:0] ST_APPEND  = 3'd0;
    localparam logic [2:0] ST_REPLACE = 3'd1;
    localparam logic [2:0] ST_KEEP    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    typedef struct packed {
        logic        carries_object;
        logic        start_new;
        logic        flush;
        logic [15:0] obj_class;
        logic        has_box;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] box_width;
        logic [15:0] box_height;
        logic [15:0] score;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [15:0] out_obj_class;
        logic        out_has_box;
        logic [15:0] out_center_x;
        logic [15:0] out_center_y;
        logic [15:0] out_box_width;
        logic [15:0] out_box_height;
        logic [15:0] out_score;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] obj_class;
        logic        has_box;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] box_width;
        logic [15:0] box_height;
        logic [15:0] score;
    } t_entry;

    typedef struct packed {
        logic       load_item;
        logic       rd_en;
        logic       cmp_issue;
        logic       kill;
        logic       wr_en;
        logic       out_load;
        logic       out_kind;
        logic [2:0] out_status;
        logic       out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic cmp_valid;
        logic cmp_match;
        logic cmp_greater;
        logic out_free;
    } t_dp_stat;

endpackage

[sv/detection_dedup_merge.sv]
// Top level of the detection merge block with overlap-based duplicate suppression.
// Depends on ddm_pkg, ddm_ctrl and ddm_datapath.
//
// Input channel i_in_valid/o_in_ready carries one detection beat; the output
// channel o_out_valid/i_out_ready carries result beats; i_cfg_valid/o_cfg_ready
// writes the 7-bit overlap threshold in hundredths, which is always ready.
// Each input beat gives one status beat, then with flush one beat per stored
// entry in slot order; last marks the final beat of an input beat.
// The duplicate scan streams one stored entry per cycle through a five-stage
// compare pipe (memory read and four compare stages) and stops early when an
// entry matches. Each flush beat takes a memory read and then an output
// register load.
// Input is taken only between items; a status beat may still wait at the
// output while the next input beat is accepted and scanned.
// A receiver stall holds the output register and pauses the sequence.
// Reset empties the table, sets the threshold to 85 and clears the output.
module detection_dedup_merge import ddm_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_dp_cmd       w_cmd;
    t_dp_stat      w_stat;
    logic [IW-1:0] w_rd_addr;
    logic [IW-1:0] w_wr_addr;
    logic [CW-1:0] w_out_slot;

    assign o_cfg_ready = 1'b1;

    ddm_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .IW(IW),
        .CW(CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr),
        .o_wr_addr  (w_wr_addr),
        .o_out_slot (w_out_slot)
    );

    ddm_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .IW(IW),
        .CW(CW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_rd_addr   (w_rd_addr),
        .i_wr_addr   (w_wr_addr),
        .i_out_slot  (w_out_slot),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[sv/ddm_datapath.sv]
// Datapath of the detection merge block: entry memory, overlap compare pipe, output register.
// Depends on ddm_pkg; driven by ddm_ctrl through t_dp_cmd.
module ddm_datapath import ddm_pkg::*; #(
    parameter int TABLE_DEPTH = 16,
    parameter int IW = 4,
    parameter int CW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_in_item      i_in_data,
    input  logic          i_cfg_valid,
    input  logic [6:0]    i_cfg_data,
    input  t_dp_cmd       i_cmd,
    input  logic [IW-1:0] i_rd_addr,
    input  logic [IW-1:0] i_wr_addr,
    input  logic [CW-1:0] i_out_slot,
    output t_dp_stat      o_stat,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output t_out_item     o_out_data
);

    function automatic logic [16:0] overlap2(input logic [15:0] ca, input logic [15:0] sa,
                                             input logic [15:0] cb, input logic [15:0] sb);
        logic signed [18:0] la, ra, lb, rb, lo, hi, d;
        la = $signed({2'b00, ca, 1'b0}) - $signed({3'b000, sa});
        ra = $signed({2'b00, ca, 1'b0}) + $signed({3'b000, sa});
        lb = $signed({2'b00, cb, 1'b0}) - $signed({3'b000, sb});
        rb = $signed({2'b00, cb, 1'b0}) + $signed({3'b000, sb});
        lo = (la > lb) ? la : lb;
        hi = (ra < rb) ? ra : rb;
        d  = hi - lo;
        return (hi > lo) ? d[16:0] : 17'd0;
    endfunction

    t_entry      r_mem [TABLE_DEPTH];
    t_entry      r_rd_data;
    t_in_item    r_item;
    logic [6:0]  r_thr;
    logic        r_v0, r_v1, r_v2, r_v3, r_v4;
    logic        r_e1, r_e2, r_e3, r_e4;
    logic        r_g1, r_g2, r_g3, r_g4;
    logic [16:0] r_ow, r_oh;
    logic [31:0] r_aa, r_ab;
    logic [33:0] r_inter;
    logic [34:0] r_area4;
    logic        r_zg, r_zg4;
    logic [34:0] r_union;
    logic [40:0] r_ip, r_ip4;
    logic [41:0] r_tp;
    logic        r_out_valid;
    t_out_item   r_out;
    t_entry      w_new;
    t_in_item    w_load;

    assign w_new.obj_class  = r_item.obj_class;
    assign w_new.has_box    = r_item.has_box;
    assign w_new.center_x   = r_item.center_x;
    assign w_new.center_y   = r_item.center_y;
    assign w_new.box_width  = r_item.box_width;
    assign w_new.box_height = r_item.box_height;
    assign w_new.score      = r_item.score;

    always_comb begin
        w_load = i_in_data;
        if (!i_in_data.has_box) begin
            w_load.center_x   = '0;
            w_load.center_y   = '0;
            w_load.box_width  = '0;
            w_load.box_height = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 7'd85;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= w_load;
        end
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= w_new;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.kill) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v0 <= i_cmd.cmp_issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e1 <= (r_rd_data.obj_class == r_item.obj_class) && r_rd_data.has_box
                && r_item.has_box;
        r_g1 <= r_item.score > r_rd_data.score;
        r_ow <= overlap2(r_rd_data.center_x, r_rd_data.box_width,
                         r_item.center_x, r_item.box_width);
        r_oh <= overlap2(r_rd_data.center_y, r_rd_data.box_height,
                         r_item.center_y, r_item.box_height);
        r_aa <= r_rd_data.box_width * r_rd_data.box_height;
        r_ab <= r_item.box_width * r_item.box_height;

        r_e2    <= r_e1;
        r_g2    <= r_g1;
        r_inter <= r_ow * r_oh;
        r_area4 <= {(33'(r_aa) + 33'(r_ab)), 2'b00};

        r_e3    <= r_e2;
        r_g3    <= r_g2;
        r_zg    <= r_area4 > 35'(r_inter);
        r_union <= r_area4 - 35'(r_inter);
        r_ip    <= 41'(r_inter) * 41'd100;

        r_e4  <= r_e3 && r_zg;
        r_g4  <= r_g3;
        r_zg4 <= r_zg;
        r_ip4 <= r_ip;
        r_tp  <= 42'(r_thr) * 42'(r_union);
    end

    assign o_stat.cmp_valid   = r_v4;
    assign o_stat.cmp_match   = r_e4 && r_zg4 && (42'(r_ip4) >= r_tp);
    assign o_stat.cmp_greater = r_g4;
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.kind   <= i_cmd.out_kind;
            r_out.status <= i_cmd.out_status;
            r_out.slot   <= 4'(i_out_slot);
            r_out.last   <= i_cmd.out_last;
            if (i_cmd.out_kind == KIND_ENTRY) begin
                r_out.out_obj_class  <= r_rd_data.obj_class;
                r_out.out_has_box    <= r_rd_data.has_box;
                r_out.out_center_x   <= r_rd_data.center_x;
                r_out.out_center_y   <= r_rd_data.center_y;
                r_out.out_box_width  <= r_rd_data.box_width;
                r_out.out_box_height <= r_rd_data.box_height;
                r_out.out_score      <= r_rd_data.score;
            end else begin
                r_out.out_obj_class  <= '0;
                r_out.out_has_box    <= 1'b0;
                r_out.out_center_x   <= '0;
                r_out.out_center_y   <= '0;
                r_out.out_box_width  <= '0;
                r_out.out_box_height <= '0;
                r_out.out_score      <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[sv/ddm_ctrl.sv]
// Controller of the detection merge block: scan, decide, status and readout sequencing.
// Depends on ddm_pkg; commands ddm_datapath through t_dp_cmd.
module ddm_ctrl import ddm_pkg::*; #(
    parameter int TABLE_DEPTH = 16,
    parameter int IW = 4,
    parameter int CW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  t_in_item      i_in_data,
    output logic          o_in_ready,
    input  t_dp_stat      i_stat,
    output t_dp_cmd       o_cmd,
    output logic [IW-1:0] o_rd_addr,
    output logic [IW-1:0] o_wr_addr,
    output logic [CW-1:0] o_out_slot
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_EMIT   = 6'b001000,
        S_FRD    = 6'b010000,
        S_FOUT   = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_issue, n_issue;
    logic [CW-1:0] r_rcv, n_rcv;
    logic [CW-1:0] r_slot, n_slot;
    logic          r_found, n_found;
    logic          r_gt, n_gt;
    logic          r_flush, n_flush;
    logic [2:0]    r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_issue  <= '0;
            r_rcv    <= '0;
            r_slot   <= '0;
            r_found  <= 1'b0;
            r_gt     <= 1'b0;
            r_flush  <= 1'b0;
            r_status <= ST_NONE;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_issue  <= n_issue;
            r_rcv    <= n_rcv;
            r_slot   <= n_slot;
            r_found  <= n_found;
            r_gt     <= n_gt;
            r_flush  <= n_flush;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_issue    = r_issue;
        n_rcv      = r_rcv;
        n_slot     = r_slot;
        n_found    = r_found;
        n_gt       = r_gt;
        n_flush    = r_flush;
        n_status   = r_status;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_rd_addr  = r_issue[IW-1:0];
        o_wr_addr  = r_slot[IW-1:0];
        o_out_slot = r_slot;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_flush = i_in_data.flush;
                    n_found = 1'b0;
                    n_issue = '0;
                    n_rcv   = '0;
                    if (i_in_data.start_new) begin
                        n_count = '0;
                    end
                    if (i_in_data.carries_object) begin
                        n_state = S_SCAN;
                    end else begin
                        n_status = ST_NONE;
                        n_slot   = '0;
                        n_state  = S_EMIT;
                    end
                end
            end
            S_SCAN: begin
                if (r_issue < r_count) begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.cmp_issue = 1'b1;
                    n_issue = r_issue + CW'(1);
                end
                if (r_count == '0) begin
                    n_state = S_DECIDE;
                end else if (i_stat.cmp_valid) begin
                    n_rcv = r_rcv + CW'(1);
                    if (i_stat.cmp_match) begin
                        n_found = 1'b1;
                        n_gt    = i_stat.cmp_greater;
                        n_slot  = r_rcv;
                        n_state = S_DECIDE;
                    end else if (r_rcv + CW'(1) == r_count) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                o_cmd.kill = 1'b1;
                n_state = S_EMIT;
                if (r_found) begin
                    if (r_gt) begin
                        o_cmd.wr_en = 1'b1;
                        n_status = ST_REPLACE;
                    end else begin
                        n_status = ST_KEEP;
                    end
                end else if (r_count < CW'(TABLE_DEPTH)) begin
                    o_cmd.wr_en = 1'b1;
                    o_wr_addr   = r_count[IW-1:0];
                    n_status    = ST_APPEND;
                    n_slot      = r_count;
                    n_count     = r_count + CW'(1);
                end else begin
                    n_status = ST_FULL;
                    n_slot   = '0;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_kind   = KIND_STATUS;
                    o_cmd.out_status = r_status;
                    o_cmd.out_last   = !(r_flush && (r_count != '0));
                    n_issue = '0;
                    n_state = (r_flush && (r_count != '0)) ? S_FRD : S_IDLE;
                end
            end
            S_FRD: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_FOUT;
            end
            S_FOUT: begin
                o_out_slot = r_issue;
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_kind   = KIND_ENTRY;
                    o_cmd.out_status = ST_APPEND;
                    o_cmd.out_last   = (r_issue + CW'(1) == r_count);
                    if (r_issue + CW'(1) == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        n_issue = r_issue + CW'(1);
                        n_state = S_FRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/ddm_checker.sv]
// Port-level checker of the detection merge block and its bind to the top level.
// Depends on ddm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ddm_checker import ddm_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_out_item  o_out_data
);

    logic w_entry_beat;
    logic w_status_beat;
    logic w_status_clear;

    assign w_entry_beat   = o_out_valid && (o_out_data.kind == KIND_ENTRY);
    assign w_status_beat  = o_out_valid && (o_out_data.kind == KIND_STATUS);
    assign w_status_clear = (o_out_data.out_obj_class == 16'd0)
                            && (o_out_data.out_score == 16'd0);

    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `AST_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data))
    `AST_IMP(a_entry_status, i_clk, i_rst_n, w_entry_beat, o_out_data.status == ST_APPEND)
    `AST_IMP(a_status_zero, i_clk, i_rst_n, w_status_beat, w_status_clear)
    `AST_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind detection_dedup_merge ddm_checker u_ddm_checker (.*);

[tb/sv/ddm_scoreboard.sv]
// Checker for the detection merge block: predicts result beats from accepted
// input and configuration beats and compares them. Depends on ddm_pkg.
module ddm_scoreboard import ddm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic [6:0] i_cfg_data,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int DEPTH = 16;

    logic [6:0]  thresh_pct;
    int          n_entries;
    t_entry      merged[DEPTH];
    t_out_item   awaited[$];

    assign o_pending = awaited.size();

    function automatic longint span_overlap(longint ca, longint sa, longint cb, longint sb);
        longint lo;
        longint hi;
        lo = (2 * ca - sa) > (2 * cb - sb) ? (2 * ca - sa) : (2 * cb - sb);
        hi = (2 * ca + sa) < (2 * cb + sb) ? (2 * ca + sa) : (2 * cb + sb);
        return hi > lo ? hi - lo : 0;
    endfunction

    function automatic bit is_overlap(t_entry a, t_in_item b);
        longint inter4;
        longint area4;
        inter4 = span_overlap(a.center_x, a.box_width, b.center_x, b.box_width)
               * span_overlap(a.center_y, a.box_height, b.center_y, b.box_height);
        area4 = 4 * longint'(a.box_width) * a.box_height
              + 4 * longint'(b.box_width) * b.box_height;
        if (area4 <= inter4) return 0;
        return inter4 * 100 >= longint'(thresh_pct) * (area4 - inter4);
    endfunction

    task automatic merge_detection(t_in_item d);
        t_out_item r;
        t_entry    e;
        int        hit;
        hit = -1;
        r = '0;
        r.status = ST_NONE;
        if (d.start_new) n_entries = 0;
        e.obj_class  = d.obj_class;
        e.has_box    = d.has_box;
        e.center_x   = d.has_box ? d.center_x : 16'd0;
        e.center_y   = d.has_box ? d.center_y : 16'd0;
        e.box_width  = d.has_box ? d.box_width : 16'd0;
        e.box_height = d.has_box ? d.box_height : 16'd0;
        e.score      = d.score;
        if (d.carries_object) begin
            for (int i = 0; i < n_entries; i++) begin
                if (hit < 0 && merged[i].obj_class == d.obj_class && merged[i].has_box
                        && d.has_box && is_overlap(merged[i], d)) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                r.slot = hit[3:0];
                if (d.score > merged[hit].score) begin
                    merged[hit] = e;
                    r.status = ST_REPLACE;
                end else begin
                    r.status = ST_KEEP;
                end
            end else if (n_entries < DEPTH) begin
                r.slot = n_entries[3:0];
                merged[n_entries] = e;
                n_entries++;
                r.status = ST_APPEND;
            end else begin
                r.status = ST_FULL;
            end
        end
        r.kind = KIND_STATUS;
        r.last = !(d.flush && n_entries > 0);
        awaited = {awaited, r};
        if (d.flush) begin
            for (int i = 0; i < n_entries; i++) begin
                r = '0;
                r.kind           = KIND_ENTRY;
                r.slot           = i[3:0];
                r.out_obj_class  = merged[i].obj_class;
                r.out_has_box    = merged[i].has_box;
                r.out_center_x   = merged[i].center_x;
                r.out_center_y   = merged[i].center_y;
                r.out_box_width  = merged[i].box_width;
                r.out_box_height = merged[i].box_height;
                r.out_score      = merged[i].score;
                r.last           = (i + 1 == n_entries);
                awaited = {awaited, r};
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            thresh_pct   <= 7'd85;
            n_entries    = 0;
            o_fail_count <= 0;
            awaited.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) thresh_pct <= i_cfg_data;
            if (i_in_valid && i_in_ready) merge_detection(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (awaited.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected beat %h", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = awaited[0];
                    awaited.delete(0);
                    if (want !== i_out_data) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch: expected %h actual %h", want, i_out_data);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[tb/sv/tb_detection_dedup_merge.sv]
// Testbench top for the detection merge block: drives detections, thresholds
// and output stalls. Depends on ddm_pkg, ddm_scoreboard and the block.
module tb_detection_dedup_merge;
    import ddm_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] cfg_data = '0;
    int         fail_count;
    int         pending;
    int         send_idle_pct = 25;
    int         recv_idle_pct = 83;
    bit         hold_off = 1'b0;
    longint     cycles = 0;
    int         sent = 0;

    always #5 i_clk = ~i_clk;

    detection_dedup_merge uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    ddm_scoreboard checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_detection(t_in_item d);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [6:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item make_detection(bit start, bit flush, bit obj);
        t_in_item d;
        d = '0;
        d.carries_object = obj;
        d.start_new      = start;
        d.flush          = flush;
        d.obj_class      = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(2));
        d.has_box        = $urandom_range(7) != 0;
        d.center_x       = 16'($urandom_range(30000, 30600));
        d.center_y       = 16'($urandom_range(20000, 20600));
        d.box_width      = 16'($urandom_range(3000, 3600));
        d.box_height     = 16'($urandom_range(3000, 3600));
        if ($urandom_range(5) == 0) begin
            d.center_x   = 16'($urandom);
            d.center_y   = 16'($urandom);
            d.box_width  = 16'($urandom);
            d.box_height = 16'($urandom);
        end
        d.score = 16'($urandom);
        return d;
    endfunction

    task automatic random_phase(int n);
        t_in_item d;
        for (int i = 0; i < n; i++) begin
            d = make_detection($urandom_range(11) == 0, $urandom_range(5) == 0,
                               $urandom_range(9) != 0);
            send_detection(d);
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        t_in_item d;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        d = '0;
        d.flush = 1'b1;
        send_detection(d);
        d = '1;
        d.start_new = 1'b1;
        d.flush = 1'b0;
        send_detection(d);
        d.start_new = 1'b0;
        d.score = 16'hFFFE;
        send_detection(d);
        d.score = 16'hFFFF;
        send_detection(d);
        d.has_box = 1'b0;
        send_detection(d);
        d = '0;
        d.carries_object = 1'b1;
        d.has_box = 1'b1;
        d.score = 16'd5;
        send_detection(d);
        d.score = 16'd6;
        send_detection(d);
        for (int i = 0; i < 12; i++) begin
            d = make_detection(1'b0, i == 11, 1'b1);
            d.obj_class = 16'(100 + i);
            send_detection(d);
        end
        in_valid <= 1'b0;
        write_threshold(7'd0);
        random_phase(15);
        write_threshold(7'd127);
        random_phase(15);
        write_threshold(7'd100);
        send_idle_pct = 83;
        recv_idle_pct = 25;
        random_phase(20);
        write_threshold(7'd50);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off <= 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            random_phase(10);
        join
        drain();
        write_threshold(7'd85);
        random_phase(25);
        drain();
        $display("Sent %0d detections over thresholds 0..127 with flushes,", sent);
        $display("full-table drops, output stalls and idle gaps.");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
